/* hw/rtl/lkv_pkg.sv */
`default_nettype none
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;
    localparam int EC_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
    localparam logic              MODE_GET       = 1'b0;
    localparam logic              MODE_SET       = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE     = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] SET_VALUE      = '0;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_key;
        logic [DATA_W-1:0] wr_value;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } mem_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/lkv_store.sv */
`default_nettype none
module lkv_store (
    input  wire logic          aclk,
    input  wire lkv_pkg::mem_req_t req,
    output lkv_pkg::mem_rsp_t  rsp
);

    logic [lkv_pkg::DATA_W-1:0] key_mem   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] value_mem [lkv_pkg::ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr]   <= req.wr_key;
            value_mem[req.wr_addr] <= req.wr_value;
        end
        rsp.key   <= key_mem[req.rd_addr];
        rsp.value <= value_mem[req.rd_addr];
    end

endmodule
`default_nettype wire

/* hw/rtl/lkv_ctrl.sv */
`default_nettype none
module lkv_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [lkv_pkg::CAP_W-1:0]     capacity,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire lkv_pkg::in_item_t             s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output lkv_pkg::out_item_t                 m_item,
    output lkv_pkg::mem_req_t                  mem_req,
    input  wire lkv_pkg::mem_rsp_t             mem_rsp
);

    localparam int IW = lkv_pkg::IDX_W;
    localparam int CW = lkv_pkg::CNT_W;

    lkv_pkg::state_t state_reg, state_next;

    logic [IW-1:0]     idx_reg, idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    lkv_pkg::in_item_t req_reg, req_next;

    logic                       found_reg, found_next;
    logic [IW-1:0]              hit_idx_reg, hit_idx_next;
    logic [IW-1:0]              hit_rank_reg, hit_rank_next;
    logic [lkv_pkg::DATA_W-1:0] hit_val_reg, hit_val_next;
    logic                       old_found_reg, old_found_next;
    logic [IW-1:0]              old_idx_reg, old_idx_next;
    logic [IW-1:0]              old_rank_reg, old_rank_next;
    logic                       free_found_reg, free_found_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;

    logic [lkv_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]               rank_reg [lkv_pkg::ENTRIES];
    logic [IW-1:0]               rank_next [lkv_pkg::ENTRIES];
    logic [CW-1:0]               used_reg, used_next;

    logic               m_valid_reg, m_valid_next;
    lkv_pkg::out_item_t m_item_reg, m_item_next;

    logic                      accept;
    logic                      out_free;
    logic                      do_update;
    logic                      key_match;
    logic                      cur_valid;
    logic [IW-1:0]             cur_rank;
    logic [lkv_pkg::EC_W-1:0]  eff_cap;
    logic                      full;
    logic                      ins_ok;
    logic                      ins_evict;
    logic [IW-1:0]             ins_slot;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign do_update = (state_reg == lkv_pkg::ST_UPDATE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // shared compare unit: one table entry per cycle
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_rank  = rank_reg[cmp_idx_reg];
    assign key_match = mem_rsp.key == req_reg.key;

    always_comb begin
        if (capacity == '0) begin
            eff_cap = lkv_pkg::EC_W'(1);
        end else if (lkv_pkg::EC_W'(capacity) > lkv_pkg::EC_W'(lkv_pkg::ENTRIES)) begin
            eff_cap = lkv_pkg::EC_W'(lkv_pkg::ENTRIES);
        end else begin
            eff_cap = lkv_pkg::EC_W'(capacity);
        end
    end

    assign full = lkv_pkg::EC_W'(used_reg) >= eff_cap;

    // insert slot choice for a set that misses
    always_comb begin
        if (full && old_found_reg) begin
            ins_slot  = old_idx_reg;
            ins_evict = 1'b1;
            ins_ok    = 1'b1;
        end else begin
            ins_slot  = free_idx_reg;
            ins_evict = 1'b0;
            ins_ok    = free_found_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_valid) state_next = lkv_pkg::ST_SCAN;
            end
            lkv_pkg::ST_SCAN: begin
                if (idx_reg == IW'(lkv_pkg::ENTRIES - 1)) state_next = lkv_pkg::ST_LAST;
            end
            lkv_pkg::ST_LAST: begin
                state_next = lkv_pkg::ST_UPDATE;
            end
            lkv_pkg::ST_UPDATE: begin
                if (out_free) state_next = lkv_pkg::ST_IDLE;
            end
            default: state_next = lkv_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready          = 1'b0;
        mem_req.rd_addr  = idx_reg;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = hit_idx_reg;
        mem_req.wr_key   = req_reg.key;
        mem_req.wr_value = req_reg.value;
        unique case (state_reg) inside
            lkv_pkg::ST_IDLE: s_ready = 1'b1;
            lkv_pkg::ST_SCAN, lkv_pkg::ST_LAST: ;
            lkv_pkg::ST_UPDATE: begin
                if (out_free && req_reg.mode == lkv_pkg::MODE_SET) begin
                    if (found_reg) begin
                        mem_req.wr_en = 1'b1;
                    end else if (ins_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ins_slot;
                    end
                end
            end
            default: s_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        idx_next        = idx_reg;
        cmp_valid_next  = state_reg == lkv_pkg::ST_SCAN;
        cmp_idx_next    = idx_reg;
        req_next        = req_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_rank_next   = old_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        if (accept) begin
            req_next        = s_item;
            idx_next        = '0;
            found_next      = 1'b0;
            old_found_next  = 1'b0;
            free_found_next = 1'b0;
        end

        if (state_reg == lkv_pkg::ST_SCAN) idx_next = idx_reg + IW'(1);

        if (cmp_valid_reg) begin
            if (cur_valid && !found_reg && key_match) begin
                found_next    = 1'b1;
                hit_idx_next  = cmp_idx_reg;
                hit_rank_next = cur_rank;
                hit_val_next  = mem_rsp.value;
            end
            if (cur_valid && (!old_found_reg || cur_rank > old_rank_reg)) begin
                old_found_next = 1'b1;
                old_idx_next   = cmp_idx_reg;
                old_rank_next  = cur_rank;
            end
            if (!cur_valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        if (do_update) begin
            m_valid_next       = 1'b1;
            m_item_next.hit    = found_reg;
            m_item_next.evicted = 1'b0;
            if (req_reg.mode == lkv_pkg::MODE_GET) begin
                m_item_next.read_value = found_reg ? hit_val_reg : lkv_pkg::MISS_VALUE;
            end else begin
                m_item_next.read_value = lkv_pkg::SET_VALUE;
            end

            if (found_reg) begin
                // move to front: entries more recent than the hit age by one
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (valid_reg[i] && rank_reg[i] < hit_rank_reg) begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
                rank_next[hit_idx_reg] = '0;
            end else if (req_reg.mode == lkv_pkg::MODE_SET && ins_ok) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (valid_reg[i] && !(ins_evict && IW'(i) == ins_slot)) begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
                rank_next[ins_slot]  = '0;
                valid_next[ins_slot] = 1'b1;
                m_item_next.evicted  = ins_evict;
                if (!ins_evict) used_next = used_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lkv_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            used_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) rank_reg[i] <= '0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            m_valid_reg   <= m_valid_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        req_reg        <= req_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_val_reg    <= hit_val_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_rank_reg   <= old_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        m_item_reg     <= m_item_next;
    end

    a_used_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) == 32'($countones(valid_reg)))
        else $error("used count does not match valid bits");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == lkv_pkg::ST_SCAN && idx_reg == '0)
        else $error("accepted word did not start a scan");

    a_update_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update |=> m_valid_reg && state_reg == lkv_pkg::ST_IDLE)
        else $error("update did not load a result");

    a_evict_only_on_set_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update && m_item_next.evicted |-> req_reg.mode == lkv_pkg::MODE_SET && !found_reg
            && used_reg != '0)
        else $error("eviction outside a set miss");

endmodule
`default_nettype wire

/* hw/rtl/lru_key_value_cache.sv */
`default_nettype none
// Fully associative 16-entry key/value cache with LRU replacement. Each input
// word is a get or a set; exactly one result word comes back per input, in
// order. A lookup scans the table one entry per cycle through the registered
// read port of the key/value memory; the result is loaded into the output
// register once that register is free, and a new word is taken only after
// that. The input side takes a new word while the previous result waits on
// the output register. The capacity register (1..16, 0 acts as 1) may be
// written only while idle; lowering it does not flush entries already held.
module lru_key_value_cache (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]  cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire lkv_pkg::in_item_t          s_item,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output lkv_pkg::out_item_t              m_item
);

    logic [lkv_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    lkv_pkg::mem_req_t         mem_req;
    lkv_pkg::mem_rsp_t         mem_rsp;

    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAPACITY_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    lkv_store u_store (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .mem_req  (mem_req),
        .mem_rsp  (mem_rsp)
    );

endmodule
`default_nettype wire
